// ===== rtl/core/bcp_pkg.sv =====
// Shared constants for the Bezier curve point evaluator.
// No dependencies; imported by bezier_curve_points, bcp_div and the bench.
package bcp_pkg;
   localparam int FIELD_W     = 24;           // coordinate word width
   localparam int VCOUNT_W    = 6;            // vertex_count width
   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 6'd16;
   localparam int QUOT_W      = FIELD_W;      // quotient bits per coordinate
   localparam int QCNT_W      = $clog2(QUOT_W);
endpackage

// ===== rtl/core/bezier_curve_points.sv =====
// Bezier curve evaluator, top level.
// Depends on bcp_pkg, bcp_ram (point store, work store) and bcp_div.
//
// Usage:
//  - req channel (valid/ready) carries one control point per word. Points
//    are stored in order, up to MAX_POINTS; extras are dropped silently.
//    A word with req_last_point set ends the list and starts evaluation.
//  - rsp channel (valid/ready) returns vertex_count+1 vertices, the last one
//    flagged by rsp_last_vertex. Vertex 0 is the first control point.
//  - csr_wr_en/csr_wr_data write vertex_count (0 acts as 1); write only
//    while idle.
// Timing:
//  - req_ready is high only while idle, so points are loaded only then.
//  - evaluation first forms V^(N-1) (V steps, N points).
//  - each vertex runs N-1 de Casteljau passes, the first over the point
//    store and later ones over the work store (one read per cycle, then a
//    drain), then ST_FETCH and ST_FETCH_W, the dividers in ST_DIV and the
//    output in ST_EMIT.
// Reset clears the point count, vertex_count (to 16) and the output valid.
// A stalled receiver holds the vertex in the output register; the next
// vertex is computed meanwhile and waits at the output until it frees.
module bezier_curve_points #(
   parameter int MAX_POINTS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [bcp_pkg::FIELD_W-1:0]    req_point_x,
   input  logic signed [bcp_pkg::FIELD_W-1:0]    req_point_y,
   input  logic                                  req_last_point,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [bcp_pkg::FIELD_W-1:0]    rsp_vertex_x,
   output logic signed [bcp_pkg::FIELD_W-1:0]    rsp_vertex_y,
   output logic                                  rsp_last_vertex,
   input  logic                                  csr_wr_en,
   input  logic [bcp_pkg::VCOUNT_W-1:0]          csr_wr_data
);
   import bcp_pkg::*;

   // accumulator width: V^(N-1) * 2^24 with V < 64, plus rounding headroom
   localparam int DW   = VCOUNT_W * (MAX_POINTS - 1) + FIELD_W + 1;
   localparam int ADW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW   = $clog2(MAX_POINTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_POW, ST_ROUND, ST_DRAIN, ST_FETCH, ST_FETCH_W, ST_DIV, ST_EMIT
   } state_type;

   state_type             state_ff;
   logic [CW-1:0]         cnt_ff;      // stored points
   logic [CW-1:0]         deg_ff;      // curve degree, points - 1
   logic [CW-1:0]         step_ff;     // power loop counter
   logic [CW-1:0]         round_ff;    // de Casteljau pass, 1..deg
   logic [CW-1:0]         rd_ff;       // read index within pass
   logic                  pend_ff;     // read data arrives this cycle
   logic [CW-1:0]         pidx_ff;     // index of that data
   logic [VCOUNT_W-1:0]   vcount_ff;   // configuration register
   logic [VCOUNT_W-1:0]   v_ff;        // effective step count
   logic [VCOUNT_W-1:0]   k_ff;        // vertex index
   logic [VCOUNT_W-1:0]   a_ff;        // V - k
   logic [DW-1:0]         pow_ff;      // V^deg
   logic [DW-1:0]         prev_x_ff;
   logic [DW-1:0]         prev_y_ff;
   logic                  rsp_valid_ff;
   logic [FIELD_W-1:0]    rsp_x_ff;
   logic [FIELD_W-1:0]    rsp_y_ff;
   logic                  rsp_last_ff;

   // memories
   logic                  ctrl_we;
   logic [ADW-1:0]        rd_addr;
   logic [2*FIELD_W-1:0]  ctrl_rd;
   logic                  work_we;
   logic [ADW-1:0]        work_wa;
   logic [2*DW-1:0]       work_wd;
   logic [2*DW-1:0]       work_rd;

   // datapath
   logic [DW-1:0]         ctrl_bx, ctrl_by, src_x, src_y, s_x, s_y;
   logic [DW+VCOUNT_W-1:0] pa_x, pb_x, pa_y, pb_y, pow_mul;
   logic [CW-1:0]         lim;
   logic [CW-1:0]         n_next;
   logic                  accept, div_start, done_x, done_y;
   logic                  emit_load;   // output register takes a vertex
   logic [QUOT_W-1:0]     q_x, q_y;
   logic [DW-1:0]         dvd_x, dvd_y, dsh;

   assign accept  = req_valid && req_ready;
   assign ctrl_we = accept && (cnt_ff < CW'(MAX_POINTS));
   assign rd_addr = (state_ff == ST_ROUND) ? rd_ff[ADW-1:0] : '0;

   bcp_ram #(.WIDTH(2*FIELD_W), .DEPTH(MAX_POINTS)) u_ctrl_ram (
      .clock   (clock),
      .wr_en   (ctrl_we),
      .wr_addr (cnt_ff[ADW-1:0]),
      .wr_data ({req_point_x, req_point_y}),
      .rd_addr (rd_addr),
      .rd_data (ctrl_rd)
   );

   // points offset to unsigned by flipping the sign bit
   assign ctrl_bx = {{(DW-FIELD_W){1'b0}}, ~ctrl_rd[2*FIELD_W-1], ctrl_rd[2*FIELD_W-2:FIELD_W]};
   assign ctrl_by = {{(DW-FIELD_W){1'b0}}, ~ctrl_rd[FIELD_W-1], ctrl_rd[FIELD_W-2:0]};

   // first pass reads the point store, later ones the work store
   assign src_x = (round_ff == CW'(1)) ? ctrl_bx : work_rd[2*DW-1:DW];
   assign src_y = (round_ff == CW'(1)) ? ctrl_by : work_rd[DW-1:0];

   assign pa_x = prev_x_ff * a_ff;
   assign pb_x = src_x * k_ff;
   assign pa_y = prev_y_ff * a_ff;
   assign pb_y = src_y * k_ff;

   assign work_we = pend_ff && (pidx_ff != '0);
   assign work_wa = ADW'(pidx_ff - CW'(1));
   assign work_wd = {pa_x[DW-1:0] + pb_x[DW-1:0], pa_y[DW-1:0] + pb_y[DW-1:0]};

   bcp_ram #(.WIDTH(2*DW), .DEPTH(MAX_POINTS)) u_work_ram (
      .clock   (clock),
      .wr_en   (work_we),
      .wr_addr (work_wa),
      .wr_data (work_wd),
      .rd_addr (rd_addr),
      .rd_data (work_rd)
   );

   // degree zero: the sum is the point itself
   assign s_x   = (deg_ff == '0) ? ctrl_bx : work_rd[2*DW-1:DW];
   assign s_y   = (deg_ff == '0) ? ctrl_by : work_rd[DW-1:0];
   assign dvd_x = s_x + (pow_ff >> 1);
   assign dvd_y = s_y + (pow_ff >> 1);
   assign dsh   = pow_ff << (QUOT_W - 1);
   assign div_start = (state_ff == ST_FETCH_W);

   bcp_div #(.WIDTH(DW)) u_div_x (
      .clock (clock), .reset (reset), .start (div_start),
      .dividend (dvd_x), .divisor_sh (dsh), .done (done_x), .quot (q_x)
   );
   bcp_div #(.WIDTH(DW)) u_div_y (
      .clock (clock), .reset (reset), .start (div_start),
      .dividend (dvd_y), .divisor_sh (dsh), .done (done_y), .quot (q_y)
   );

   assign pow_mul = pow_ff * v_ff;
   assign lim     = deg_ff - round_ff + CW'(1);
   assign n_next  = ctrl_we ? cnt_ff + CW'(1) : cnt_ff;

   assign emit_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_vertex_x    = rsp_x_ff;
   assign rsp_vertex_y    = rsp_y_ff;
   assign rsp_last_vertex = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         vcount_ff    <= VCOUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            vcount_ff <= csr_wr_data;
         end
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // read pipeline: one word per cycle during a pass
         pend_ff <= (state_ff == ST_ROUND);
         pidx_ff <= rd_ff;
         if (pend_ff) begin
            prev_x_ff <= src_x;
            prev_y_ff <= src_y;
         end

         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_last_point) begin
                     cnt_ff   <= '0;
                     deg_ff   <= n_next - CW'(1);
                     v_ff     <= (vcount_ff == '0) ? VCOUNT_W'(1) : vcount_ff;
                     pow_ff   <= DW'(1);
                     step_ff  <= '0;
                     state_ff <= ST_POW;
                  end else begin
                     cnt_ff   <= n_next;
                  end
               end
            end
            ST_POW: begin
               if (step_ff == deg_ff) begin
                  k_ff     <= '0;
                  a_ff     <= v_ff;
                  round_ff <= CW'(1);
                  rd_ff    <= '0;
                  state_ff <= (deg_ff == '0) ? ST_FETCH : ST_ROUND;
               end else begin
                  pow_ff  <= pow_mul[DW-1:0];
                  step_ff <= step_ff + CW'(1);
               end
            end
            ST_ROUND: begin
               if (rd_ff == lim) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  rd_ff <= rd_ff + CW'(1);
               end
            end
            ST_DRAIN: begin
               rd_ff <= '0;
               if (round_ff == deg_ff) begin
                  state_ff <= ST_FETCH;
               end else begin
                  round_ff <= round_ff + CW'(1);
                  state_ff <= ST_ROUND;
               end
            end
            ST_FETCH: begin
               state_ff <= ST_FETCH_W;
            end
            ST_FETCH_W: begin
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (done_x && done_y) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (emit_load) begin
                  rsp_x_ff     <= {~q_x[QUOT_W-1], q_x[QUOT_W-2:0]};
                  rsp_y_ff     <= {~q_y[QUOT_W-1], q_y[QUOT_W-2:0]};
                  rsp_last_ff  <= (k_ff == v_ff);
                  if (k_ff == v_ff) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     k_ff     <= k_ff + VCOUNT_W'(1);
                     a_ff     <= a_ff - VCOUNT_W'(1);
                     round_ff <= CW'(1);
                     rd_ff    <= '0;
                     state_ff <= (deg_ff == '0) ? ST_FETCH : ST_ROUND;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // no read may be in flight once the block returns to idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_ff)
      else $error("read pending while idle");

   // a pending read's index never exceeds the curve degree
   assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (pidx_ff <= deg_ff))
      else $error("work index beyond degree");

   // the point count never exceeds the store depth
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_POINTS))
      else $error("point count overflow");

   // a vertex is loaded only after the dividers finish
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (done_x && done_y))
      else $error("emit before divide done");
endmodule

// ===== rtl/core/bcp_ram.sv =====
// Generic simple dual port RAM, one write port, one registered read port.
// No dependencies.
module bcp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== rtl/core/bcp_div.sv =====
// Restoring divider, one quotient bit per cycle, QUOT_W bits per run.
// Depends on bcp_pkg. Divisor comes in pre-shifted by QUOT_W-1.
module bcp_div #(
   parameter int WIDTH = 67
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [WIDTH-1:0]            dividend,
   input  logic [WIDTH-1:0]            divisor_sh,
   output logic                        done,
   output logic [bcp_pkg::QUOT_W-1:0]  quot
);
   import bcp_pkg::*;

   logic [WIDTH-1:0]  rem_ff;
   logic [WIDTH-1:0]  dsh_ff;
   logic [QUOT_W-1:0] q_ff;
   logic [QCNT_W-1:0] cnt_ff;
   logic              run_ff;
   logic              ge;

   assign ge   = (rem_ff >= dsh_ff);
   assign done = ~run_ff;
   assign quot = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         rem_ff <= dividend;
         dsh_ff <= divisor_sh;
         q_ff   <= '0;
         cnt_ff <= '0;
         run_ff <= 1'b1;
      end else if (run_ff) begin
         if (ge) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         q_ff   <= {q_ff[QUOT_W-2:0], ge};
         dsh_ff <= dsh_ff >> 1;
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == QCNT_W'(QUOT_W - 1)) begin
            run_ff <= 1'b0;
         end
      end
   end
endmodule

// ===== bench/tb_bezier_curve_points.sv =====
// Testbench for bezier_curve_points: control points in, curve vertices out.
// Depends on bcp_pkg and the bezier_curve_points RTL; holds its own
// exact-integer Bernstein predictor and checks every vertex word.
module tb_bezier_curve_points;
   import bcp_pkg::*;

   localparam int NPTS      = 8;          // MAX_POINTS of the instance
   localparam int LIMIT_CYC = 5_000_000;  // run ends here no matter what
   localparam int SETTLE    = 80;         // idle wait before a csr write
   localparam logic [FIELD_W-1:0] BIAS = 24'h800000;
   localparam logic [FIELD_W-1:0] MAXP = 24'h7FFFFF;
   localparam logic [FIELD_W-1:0] MINN = 24'h800000;

   typedef struct packed {
      logic [FIELD_W-1:0] x;
      logic [FIELD_W-1:0] y;
      logic               last;
   } vertex_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [FIELD_W-1:0] req_point_x = '0;
   logic signed [FIELD_W-1:0] req_point_y = '0;
   logic req_last_point = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [FIELD_W-1:0] rsp_vertex_x;
   logic signed [FIELD_W-1:0] rsp_vertex_y;
   logic rsp_last_vertex;
   logic csr_wr_en = 1'b0;
   logic [VCOUNT_W-1:0] csr_wr_data = '0;

   // predictor state: point store per axis, fill count, step count
   logic [FIELD_W-1:0] ctrl_pts [2][NPTS];
   int                 held_points;
   int                 steps;
   vertex_type         vertex_queue [$];

   int errors      = 0;
   int cycles      = 0;
   int words_sent  = 0;
   int vertices_ok = 0;
   int curves      = 0;
   int burst_left  = 0;
   int hold_req    = 0;      // written by the test sequence only
   int hold_served = 0;      // written by the receiver process only
   int hold_left   = 0;
   int stall_mode  = 0;

   bezier_curve_points #(.MAX_POINTS(NPTS)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_point_x(req_point_x), .req_point_y(req_point_y),
      .req_last_point(req_last_point),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_vertex_x(rsp_vertex_x), .rsp_vertex_y(rsp_vertex_y),
      .rsp_last_vertex(rsp_last_vertex),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Exact Bernstein sum for one axis of vertex k: sum C(d,i)(v-k)^(d-i) k^i P_i,
   // with points biased to unsigned, then one round-half-up division by v^d.
   function automatic logic [FIELD_W-1:0] bernstein_coord(int axis, int n, int k, int v);
      logic [127:0] acc, term, scale, coef;
      int deg;
      acc = '0;
      deg = n - 1;
      for (int i = 0; i < n; i++) begin
         coef = 1;
         for (int j = 0; j < i; j++)
            coef = coef * (deg - j) / (j + 1);
         term = coef;
         for (int e = 0; e < deg - i; e++)
            term = term * (v - k);
         for (int e = 0; e < i; e++)
            term = term * k;
         term = term * {104'd0, ctrl_pts[axis][i] ^ BIAS};
         acc = acc + term;
      end
      scale = 1;
      for (int e = 0; e < deg; e++)
         scale = scale * v;
      acc = (acc + scale / 2) / scale;
      return acc[FIELD_W-1:0] ^ BIAS;
   endfunction

   // Predictor update for one accepted word.
   task automatic absorb_point(logic [FIELD_W-1:0] px, logic [FIELD_W-1:0] py,
                               logic last);
      vertex_type vx;
      int v;
      if (held_points < NPTS) begin
         ctrl_pts[0][held_points] = px;
         ctrl_pts[1][held_points] = py;
         held_points++;
      end
      if (last) begin
         v = (steps == 0) ? 1 : steps;
         for (int k = 0; k <= v; k++) begin
            vx.x    = bernstein_coord(0, held_points, k, v);
            vx.y    = bernstein_coord(1, held_points, k, v);
            vx.last = (k == v);
            vertex_queue = {vertex_queue, vx};
         end
         held_points = 0;
         curves++;
      end
   endtask

   // Sends one word. Called at a rising edge; returns at the accepting edge,
   // with valid still high so a following word needs no second assignment.
   task automatic send_point(logic [FIELD_W-1:0] px, logic [FIELD_W-1:0] py,
                             logic last);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_point_x    <= px;
      req_point_y    <= py;
      req_last_point <= last;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      absorb_point(px, py, last);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (vertex_queue.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_steps(int value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[VCOUNT_W-1:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      steps = value & 63;
   endtask

   task automatic send_curve(int n);
      for (int i = 0; i < n; i++)
         send_point(FIELD_W'($urandom), FIELD_W'($urandom), i == n - 1);
   endtask

   task automatic test_reset();
      held_points = 0;
      steps       = VCOUNT_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
   endtask

   // extremes, single point, full store, overflow with and without last
   task automatic test_directed();
      send_point(MAXP, MINN, 1'b1);                   // one point, reset step count
      send_point(MINN, MINN, 1'b0);
      send_point(MAXP, MAXP, 1'b1);
      write_steps(0);                                 // zero acts as one
      send_point(MAXP, MINN, 1'b0);
      send_point(MINN, MAXP, 1'b0);
      send_point(24'h000080, 24'hFFFF80, 1'b1);       // near zero; with one step the division is exact
      write_steps(63);
      for (int i = 0; i < NPTS; i++)
         send_point(i[0] ? MAXP : MINN, i[1] ? MINN : MAXP, i == NPTS - 1);
      write_steps(3);
      for (int i = 0; i < NPTS + 2; i++)              // two dropped points, the second one last
         send_point(FIELD_W'($urandom), FIELD_W'($urandom), i == NPTS + 1);
      for (int i = 0; i < NPTS; i++)                  // last word itself is dropped
         send_point(FIELD_W'($urandom), FIELD_W'($urandom), 1'b0);
      send_point(24'h123456, 24'h654321, 1'b1);
   endtask

   task automatic test_random();
      int sent;
      int n;
      sent = 0;
      while (sent < 70) begin
         if ($urandom_range(0, 4) == 0)
            write_steps(($urandom_range(0, 5) == 0) ? $urandom_range(0, 63)
                                                      : $urandom_range(1, 8));
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 11) : $urandom_range(1, NPTS);
         send_curve(n);
         sent += n;
      end
   endtask

   // receiver holds off a long time while curves keep coming in
   task automatic test_backpressure();
      write_steps(12);
      hold_req = hold_req + 1;
      send_curve(4);
      send_curve(3);
      send_curve(5);
   endtask

   // receiver: ready follows a randomly chosen pattern, with a long hold when the test asks for one
   always @(posedge clock) begin
      if (cycles % 64 == 0)
         stall_mode <= $urandom_range(0, 2);
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_req) begin
         rsp_ready   <= 1'b0;
         hold_left   <= 400;
         hold_served <= hold_req;
      end else begin
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // vertex checker: compare every accepted word against the oldest expectation
   always @(posedge clock) begin
      vertex_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (vertex_queue.size() == 0) begin
            $error("unexpected vertex x=%h y=%h", rsp_vertex_x, rsp_vertex_y);
            errors++;
         end else begin
            want = vertex_queue.pop_front();
            if (rsp_vertex_x !== want.x) begin
               $error("vertex_x expected %h got %h", want.x, rsp_vertex_x);
               errors++;
            end
            if (rsp_vertex_y !== want.y) begin
               $error("vertex_y expected %h got %h", want.y, rsp_vertex_y);
               errors++;
            end
            if (rsp_last_vertex !== want.last) begin
               $error("last_vertex expected %b got %b", want.last, rsp_last_vertex);
               errors++;
            end
            vertices_ok++;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYC) begin
         $display("timeout with %0d vertices outstanding", vertex_queue.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      @(posedge clock);
      test_reset();
      test_directed();
      test_random();
      test_backpressure();
      write_steps(1);                                 // leave with a short setting
      send_curve(2);
      wait_drained();
      if (vertex_queue.size() != 0)
         errors++;
      $display("sent %0d point words in %0d curves, checked %0d vertices",
               words_sent, curves, vertices_ok);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
